// File: hw/rtl/breath_trapezoid_setpoint_generator_defines.svh
// Assertion macros used by the checker of this block.
`ifndef BREATH_TRAPEZOID_SETPOINT_GENERATOR_DEFINES_SVH
`define BREATH_TRAPEZOID_SETPOINT_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bts_checker: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bts_checker: assertion failed");

`endif

// File: hw/rtl/bts_pkg.sv
package bts_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned CntW   = 16;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [CodeW-1:0] PHASE_CODE_RESET   = 3'd0;
  localparam logic [CodeW-1:0] PHASE_CODE_RISE    = 3'd1;
  localparam logic [CodeW-1:0] PHASE_CODE_PLATEAU = 3'd2;
  localparam logic [CodeW-1:0] PHASE_CODE_FALL    = 3'd3;
  localparam logic [CodeW-1:0] PHASE_CODE_DWELL   = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_BASE_LEVEL    = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_PEAK_LEVEL    = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_PLATEAU_LEVEL = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_RISE_STEP     = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_FALL_STEP     = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_RISE_TICKS    = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_PLATEAU_TICKS = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_FALL_TICKS    = 4'd7;

  typedef enum logic [4:0] {
    PhReset   = 5'b00001,
    PhRise    = 5'b00010,
    PhPlateau = 5'b00100,
    PhFall    = 5'b01000,
    PhDwell   = 5'b10000
  } phase_e;

  function automatic logic [CodeW-1:0] phase_code(input phase_e ph);
    logic [CodeW-1:0] code;
    case (ph)
      PhReset:   code = PHASE_CODE_RESET;
      PhRise:    code = PHASE_CODE_RISE;
      PhPlateau: code = PHASE_CODE_PLATEAU;
      PhFall:    code = PHASE_CODE_FALL;
      PhDwell:   code = PHASE_CODE_DWELL;
      default:   code = PHASE_CODE_RESET;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/breath_trapezoid_setpoint_generator.sv
// Breath setpoint generator: each accepted item is one control tick that steps a trapezoidal
// waveform through reset, rise, plateau, fall and low dwell, and yields one result item with
// the setpoint (unsigned 8.8) and the phase after that tick. An item with advance low only
// reports the current setpoint and phase. One item is taken every cycle unless the output
// stalls; its result appears in the output register, the only stage, in the cycle after
// acceptance, and input ready follows that register being empty or being taken. Registers are
// written through the configuration channel, which is always ready; write them only while the block is idle.
module breath_trapezoid_setpoint_generator
  import bts_pkg::*;
#(
  parameter int unsigned DWELL_TICKS = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] advance, [7:1] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] setpoint, [18:16] phase, [23:19] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [CntW-1:0] DwellLimit = CntW'(DWELL_TICKS);

  logic [LevelW-1:0] base_q, peak_q, plat_q, rise_step_q, fall_step_q;
  logic [CntW-1:0]   rise_ticks_q, plat_ticks_q, fall_ticks_q;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LevelW-1:0] level_q, level_d;

  logic              out_valid_q;
  logic [LevelW-1:0] out_level_q;
  logic [CodeW-1:0]  out_code_q;

  logic              accept;
  logic [CntW-1:0]   cnt_inc, limit;
  logic              expire;
  logic [LevelW:0]   rise_sum;
  logic [LevelW-1:0] rise_sat, fall_diff;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      peak_q       <= {LevelW{1'b1}};
      plat_q       <= '0;
      rise_step_q  <= '0;
      fall_step_q  <= '0;
      rise_ticks_q <= '0;
      plat_ticks_q <= '0;
      fall_ticks_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BASE_LEVEL:    base_q       <= cfg_data_i;
        CFG_PEAK_LEVEL:    peak_q       <= cfg_data_i;
        CFG_PLATEAU_LEVEL: plat_q       <= cfg_data_i;
        CFG_RISE_STEP:     rise_step_q  <= cfg_data_i;
        CFG_FALL_STEP:     fall_step_q  <= cfg_data_i;
        CFG_RISE_TICKS:    rise_ticks_q <= cfg_data_i;
        CFG_PLATEAU_TICKS: plat_ticks_q <= cfg_data_i;
        CFG_FALL_TICKS:    fall_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_q)
      PhRise:    limit = rise_ticks_q;
      PhPlateau: limit = plat_ticks_q;
      PhFall:    limit = fall_ticks_q;
      PhDwell:   limit = DwellLimit;
      default:   limit = '0;
    endcase
  end

  assign cnt_inc   = (cnt_q != CntMax) ? cnt_q + CntW'(1) : cnt_q;
  assign expire    = cnt_inc > limit;
  assign rise_sum  = {1'b0, level_q} + {1'b0, rise_step_q};
  assign rise_sat  = rise_sum[LevelW] ? {LevelW{1'b1}} : rise_sum[LevelW-1:0];
  assign fall_diff = (level_q > fall_step_q) ? level_q - fall_step_q : '0;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    if (s_axis_tdata_i[0]) begin
      cnt_d = expire ? '0 : cnt_inc;
      case (phase_q)
        PhReset: begin
          cnt_d   = '0;
          level_d = base_q;
          phase_d = PhRise;
        end
        PhRise: begin
          level_d = (rise_sat > peak_q) ? peak_q : rise_sat;
          if (expire) phase_d = PhPlateau;
        end
        PhPlateau: begin
          level_d = plat_q;
          if (expire) phase_d = PhFall;
        end
        PhFall: begin
          level_d = (fall_diff < base_q) ? base_q : fall_diff;
          if (expire) phase_d = PhDwell;
        end
        PhDwell: begin
          level_d = base_q;
          if (expire) phase_d = PhReset;
        end
        default: begin
          cnt_d   = cnt_q;
          phase_d = PhReset;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhReset;
      cnt_q       <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        level_q <= level_d;
      end
      if (s_axis_tready_o) out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_level_q <= level_d;
      out_code_q  <= phase_code(phase_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_code_q, out_level_q};

endmodule

// File: hw/rtl/bts_checker.sv
`include "breath_trapezoid_setpoint_generator_defines.svh"

module bts_checker
  import bts_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_i
);

  logic out_stall;
  logic result_ok;

  assign out_stall = m_axis_tvalid_i && !m_axis_tready_i;
  assign result_ok = (m_axis_tdata_i[18:16] <= PHASE_CODE_DWELL) &&
                     (m_axis_tdata_i[23:19] == 5'b0);

  // A stalled result must keep its value.
  `BTS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_i && $stable(m_axis_tdata_i))
  // Every accepted item produces a result in the next cycle.
  `BTS_ASSERT_NEXT(a_result_follows, s_axis_tvalid_i && s_axis_tready_i, m_axis_tvalid_i)
  // An empty output stage never blocks the input.
  `BTS_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid_i, s_axis_tready_i)
  // Results carry a defined phase and zero padding.
  `BTS_ASSERT_NOW(a_phase_range, m_axis_tvalid_i, result_ok)

endmodule

bind breath_trapezoid_setpoint_generator bts_checker u_bts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

// File: tb/sv/tb_breath_trapezoid_setpoint_generator.sv
`timescale 1ns / 1ps

module tb_breath_trapezoid_setpoint_generator;
  import bts_pkg::*;

  localparam int unsigned DwellTicks = 100;
  localparam int unsigned NumCfgRegs = 8;
  localparam int unsigned NumRandomSettings = 8;
  localparam int unsigned TicksPerSetting = 75;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxPrinted = 30;
  localparam logic [LevelW-1:0] LevelMax = {LevelW{1'b1}};

  typedef struct packed {
    logic [LevelW-1:0] setpoint;
    logic [CodeW-1:0]  phase;
  } tick_result_t;

  typedef struct packed {
    logic         advance;
    logic         typed;
    tick_result_t result;
  } tick_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  breath_trapezoid_setpoint_generator #(
    .DWELL_TICKS(DwellTicks)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  logic [LevelW-1:0] base_lvl = '0;
  logic [LevelW-1:0] peak_lvl = LevelMax;
  logic [LevelW-1:0] plat_lvl = '0;
  logic [LevelW-1:0] up_step = '0;
  logic [LevelW-1:0] down_step = '0;
  logic [CntW-1:0]   up_limit = '0;
  logic [CntW-1:0]   hold_limit = '0;
  logic [CntW-1:0]   down_limit = '0;

  logic [CodeW-1:0]  wave_phase = PHASE_CODE_RESET;
  logic [CntW-1:0]   wave_count = '0;
  logic [LevelW-1:0] wave_level = '0;

  tick_result_t setpoints_due[$];

  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 0;
  int unsigned breaths = 0;
  int unsigned cycles = 0;

  bit steady = 1'b0;
  bit hold_trigger = 1'b0;
  bit hold_served = 1'b0;
  int unsigned hold_left = 0;

  tick_row_t tick_table [12] = '{
    '{1'b0, 1'b1, '{16'h0000, PHASE_CODE_RESET}},
    '{1'b1, 1'b1, '{16'hFF00, PHASE_CODE_RISE}},
    '{1'b1, 1'b1, '{16'hFFFF, PHASE_CODE_RISE}},
    '{1'b0, 1'b1, '{16'hFFFF, PHASE_CODE_RISE}},
    '{1'b1, 1'b1, '{16'hFFFF, PHASE_CODE_PLATEAU}},
    '{1'b1, 1'b1, '{16'hFFFF, PHASE_CODE_FALL}},
    '{1'b1, 1'b1, '{16'hFF00, PHASE_CODE_FALL}},
    '{1'b0, 1'b1, '{16'hFF00, PHASE_CODE_FALL}},
    '{1'b1, 1'b1, '{16'hFF00, PHASE_CODE_DWELL}},
    '{1'b0, 1'b1, '{16'hFF00, PHASE_CODE_DWELL}},
    '{1'b1, 1'b0, '{16'h0000, PHASE_CODE_RESET}},
    '{1'b1, 1'b0, '{16'h0000, PHASE_CODE_RESET}}
  };

  function automatic bit count_expired(input logic [CntW-1:0] limit);
    if (wave_count != CntMax) begin
      wave_count = wave_count + 1'b1;
    end
    if (wave_count > limit) begin
      wave_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic tick_result_t step_waveform(input logic advance);
    logic [LevelW:0] sum;
    if (advance) begin
      case (wave_phase)
        PHASE_CODE_RESET: begin
          wave_count = '0;
          wave_level = base_lvl;
          wave_phase = PHASE_CODE_RISE;
        end
        PHASE_CODE_RISE: begin
          sum = {1'b0, wave_level} + {1'b0, up_step};
          wave_level = sum[LevelW] ? LevelMax : sum[LevelW-1:0];
          if (wave_level > peak_lvl) begin
            wave_level = peak_lvl;
          end
          if (count_expired(up_limit)) begin
            wave_phase = PHASE_CODE_PLATEAU;
          end
        end
        PHASE_CODE_PLATEAU: begin
          wave_level = plat_lvl;
          if (count_expired(hold_limit)) begin
            wave_phase = PHASE_CODE_FALL;
          end
        end
        PHASE_CODE_FALL: begin
          wave_level = (wave_level > down_step) ? wave_level - down_step : '0;
          if (wave_level < base_lvl) begin
            wave_level = base_lvl;
          end
          if (count_expired(down_limit)) begin
            wave_phase = PHASE_CODE_DWELL;
          end
        end
        PHASE_CODE_DWELL: begin
          wave_level = base_lvl;
          if (count_expired(CntW'(DwellTicks))) begin
            wave_phase = PHASE_CODE_RESET;
            breaths++;
          end
        end
        default: begin
          wave_phase = PHASE_CODE_RESET;
        end
      endcase
    end
    return '{wave_level, wave_phase};
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic send_tick(input logic advance, input logic typed, input tick_result_t typed_result);
    tick_result_t predicted;
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'b0, advance};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = step_waveform(advance);
    setpoints_due.push_back(typed ? typed_result : predicted);
    ticks_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (setpoints_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BASE_LEVEL:    base_lvl = value;
      CFG_PEAK_LEVEL:    peak_lvl = value;
      CFG_PLATEAU_LEVEL: plat_lvl = value;
      CFG_RISE_STEP:     up_step = value;
      CFG_FALL_STEP:     down_step = value;
      CFG_RISE_TICKS:    up_limit = value;
      CFG_PLATEAU_TICKS: hold_limit = value;
      CFG_FALL_TICKS:    down_limit = value;
      default: ;
    endcase
  endtask

  task automatic program_waveform(input logic [15:0] base, input logic [15:0] peak,
                                  input logic [15:0] plateau, input logic [15:0] rise,
                                  input logic [15:0] fall, input logic [15:0] rise_len,
                                  input logic [15:0] plateau_len, input logic [15:0] fall_len);
    write_reg(CFG_BASE_LEVEL, base);
    write_reg(CFG_PEAK_LEVEL, peak);
    write_reg(CFG_PLATEAU_LEVEL, plateau);
    write_reg(CfgIdxW'($urandom_range(NumCfgRegs, 2 ** CfgIdxW - 1)), 16'($urandom));
    write_reg(CFG_RISE_STEP, rise);
    write_reg(CFG_FALL_STEP, fall);
    write_reg(CFG_RISE_TICKS, rise_len);
    write_reg(CFG_PLATEAU_TICKS, plateau_len);
    write_reg(CFG_FALL_TICKS, fall_len);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] random_step();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h0800)) : 16'($urandom);
  endfunction

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trigger && !hold_served) begin
      m_axis_tready_i <= 1'b0;
      hold_served <= 1'b1;
      hold_left <= HoldOffCycles;
    end else begin
      m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (setpoints_due.size() == 0) begin
        report_mismatch($sformatf("result %h with no tick outstanding", m_axis_tdata_o));
      end else begin
        want = setpoints_due.pop_front();
        if (m_axis_tdata_o[15:0] !== want.setpoint) begin
          report_mismatch($sformatf("setpoint %h, expected %h",
                                    m_axis_tdata_o[15:0], want.setpoint));
        end
        if (m_axis_tdata_o[18:16] !== want.phase) begin
          report_mismatch($sformatf("phase %0d, expected %0d",
                                    m_axis_tdata_o[18:16], want.phase));
        end
        if (m_axis_tdata_o[23:19] !== '0) begin
          report_mismatch($sformatf("padding bits %b are not zero", m_axis_tdata_o[23:19]));
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, setpoints_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] base, peak, plateau, rise, fall, rise_len, plateau_len, fall_len;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Steps large enough to saturate both ramps, with a base level near the top.
    program_waveform(16'hFF00, LevelMax, LevelMax, LevelMax, LevelMax, 16'd1, 16'd0, 16'd1);
    foreach (tick_table[r]) begin
      send_tick(tick_table[r].advance, tick_table[r].typed, tick_table[r].result);
    end

    for (int s = 0; s < NumRandomSettings; s++) begin
      drain();
      if (s == 0) begin
        program_waveform('0, '0, '0, '0, '0, '0, '0, '0);
      end else if (s == 1) begin
        program_waveform(LevelMax, LevelMax, LevelMax, LevelMax, LevelMax,
                         CntMax - 1'b1, CntMax - 1'b1, CntMax - 1'b1);
      end else begin
        base = 16'($urandom);
        peak = 16'($urandom);
        plateau = 16'($urandom);
        rise = random_step();
        fall = random_step();
        rise_len = 16'($urandom_range(0, 12));
        plateau_len = 16'($urandom_range(0, 12));
        fall_len = 16'($urandom_range(0, 12));
        program_waveform(base, peak, plateau, rise, fall, rise_len, plateau_len, fall_len);
      end
      steady = (s == 3);
      for (int i = 0; i < TicksPerSetting; i++) begin
        if (s == 4 && i == 20) begin
          hold_trigger = 1'b1;
        end
        if (s == 5 && i == 30) begin
          drain();
        end
        send_tick($urandom_range(0, 99) < 88, 1'b0, '0);
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    $display("Sent %0d ticks under %0d register settings, %0d results checked.",
             ticks_sent, settings_used, results_checked);
    $display("The predicted waveform completed %0d full breaths.", breaths);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
